// ===== src/ffra_pkg.sv =====
// Package for the first-fit run allocator: sizes, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

    // Map size and cell geometry
    localparam int MAX_ENTRIES = 256;
    localparam int CELL_SH     = 3;
    localparam int CELL_SLOTS  = 1 << CELL_SH;
    localparam int NUM_CELLS   = (MAX_ENTRIES + CELL_SLOTS - 1) / CELL_SLOTS;
    localparam int CELL_W      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    // Field widths
    localparam int LEN_W    = 9;
    localparam int IDX_W    = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    // Counter / slot arithmetic width: holds every slot number, the map size and a length
    localparam int SPAN_W = $clog2(NUM_CELLS * CELL_SLOTS + 1);
    localparam int CNT_W  = (SPAN_W > LEN_W) ? SPAN_W : LEN_W;

    // Opcodes and status codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_FAIL  = 1'b1;

    // Scan token passed from cell to cell
    typedef struct packed {
        logic             active;
        logic             found;
        logic [CNT_W-1:0] run;
        logic [CNT_W-1:0] start;
    } scan_t;

    // Map update broadcast to all cells
    typedef struct packed {
        logic             mark_en;
        logic             clr_en;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
    } map_wr_t;

endpackage

`default_nettype wire

// ===== src/ffra_cell.sv =====
// One cell of the allocator chain: eight in-use bits and one step of the first-fit scan.
`timescale 1ns / 1ps
`default_nettype none

module ffra_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [ffra_pkg::CELL_W-1:0] cell_idx,
    input  wire logic [ffra_pkg::LEN_W-1:0]  len,
    input  wire ffra_pkg::scan_t           scan_in,
    input  wire ffra_pkg::map_wr_t         wr,
    output ffra_pkg::scan_t                scan_out
);

    logic [ffra_pkg::CELL_SLOTS-1:0] bits_reg;
    logic [ffra_pkg::CELL_SLOTS-1:0] bits_next;
    ffra_pkg::scan_t                 scan_reg;
    ffra_pkg::scan_t                 scan_next;
    logic [ffra_pkg::CNT_W-1:0]      base;

    assign base = ffra_pkg::CNT_W'(cell_idx) << ffra_pkg::CELL_SH;

    // Scan step over this cell's slots, lowest first
    always_comb begin
        logic [ffra_pkg::CNT_W-1:0] s;
        logic [ffra_pkg::CNT_W-1:0] len_ext;
        logic                       used;
        len_ext   = ffra_pkg::CNT_W'(len);
        scan_next = scan_in;
        for (int j = 0; j < ffra_pkg::CELL_SLOTS; j++) begin
            s    = base + ffra_pkg::CNT_W'(j);
            used = bits_reg[j] || (s >= ffra_pkg::CNT_W'(ffra_pkg::MAX_ENTRIES));
            if (used) begin
                scan_next.run = '0;
            end else begin
                scan_next.run = scan_next.run + ffra_pkg::CNT_W'(1);
                if (!scan_next.found && (len_ext == '0 || scan_next.run == len_ext)) begin
                    scan_next.found = 1'b1;
                    scan_next.start = (len_ext == '0) ? s
                                                      : s + ffra_pkg::CNT_W'(1) - len_ext;
                end
            end
        end
    end

    // Map update: set a run or clear one slot
    always_comb begin
        logic [ffra_pkg::CNT_W-1:0] s;
        bits_next = bits_reg;
        for (int j = 0; j < ffra_pkg::CELL_SLOTS; j++) begin
            s = base + ffra_pkg::CNT_W'(j);
            if (wr.mark_en && s >= wr.lo && s <= wr.hi) begin
                bits_next[j] = 1'b1;
            end
            if (wr.clr_en && s == wr.lo) begin
                bits_next[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg        <= '0;
            scan_reg.active <= 1'b0;
        end else begin
            bits_reg        <= bits_next;
            scan_reg.active <= scan_in.active;
            if (scan_in.active) begin
                scan_reg.found <= scan_next.found;
                scan_reg.run   <= scan_next.run;
                scan_reg.start <= scan_next.start;
            end
        end
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

// ===== src/first_fit_run_allocator_core.sv =====
// Top level of the first-fit run allocator: request control, cell chain and result register.
//
// Channel | Dir | tdata (low bit up)                       | tuser
// s_      | in  | run_length[8:0], slot_index[16:9], pad 0 | opcode
// m_      | out | start_slot[7:0]                          | status
//
// An allocate sends a scan token down the chain of NUM_CELLS cells, one cell
// (eight slots) per cycle; the result then goes to the output register from S_RESP.
// A free updates the map at accept and gives its result through S_RESP.
// One request is in flight at a time; a new one is accepted while the result waits.
// aresetn (synchronous) clears the whole map at once, every slot free.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_run_allocator_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ffra_pkg::S_DATA_W-1:0] s_tdata,  // run_length, slot_index
    input  wire logic                          s_tuser,  // opcode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ffra_pkg::M_DATA_W-1:0]      m_tdata,  // start_slot
    output logic                               m_tuser   // status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t                          state_reg;
    logic                            go_reg;
    logic [ffra_pkg::LEN_W-1:0]      len_reg;
    logic                            res_status_reg;
    logic [ffra_pkg::IDX_W-1:0]      res_slot_reg;
    logic                            m_tvalid_reg;
    logic [ffra_pkg::M_DATA_W-1:0]   m_tdata_reg;
    logic                            m_tuser_reg;

    logic                            s_accept;
    logic [ffra_pkg::LEN_W-1:0]      in_len;
    logic [ffra_pkg::IDX_W-1:0]      in_idx;
    logic [ffra_pkg::CNT_W-1:0]      in_idx_ext;
    logic                            free_oob;
    logic                            scan_done;
    ffra_pkg::scan_t                 chain [ffra_pkg::NUM_CELLS+1];
    ffra_pkg::map_wr_t               wr;
    logic [ffra_pkg::NUM_CELLS:0]    act_vec;

    // Input decode
    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign in_len     = s_tdata[ffra_pkg::LEN_W-1:0];
    assign in_idx     = s_tdata[ffra_pkg::LEN_W +: ffra_pkg::IDX_W];
    assign in_idx_ext = ffra_pkg::CNT_W'(in_idx);
    assign free_oob   = in_idx_ext >= ffra_pkg::CNT_W'(ffra_pkg::MAX_ENTRIES);

    // Token launch into the first cell
    assign chain[0] = '{active: go_reg, found: 1'b0, run: '0, start: '0};

    genvar gi;
    generate
        for (gi = 0; gi < ffra_pkg::NUM_CELLS; gi++) begin : g_cell
            ffra_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (ffra_pkg::CELL_W'(gi)),
                .len      (len_reg),
                .scan_in  (chain[gi]),
                .wr       (wr),
                .scan_out (chain[gi+1])
            );
        end
        for (gi = 0; gi <= ffra_pkg::NUM_CELLS; gi++) begin : g_act
            assign act_vec[gi] = chain[gi].active;
        end
    endgenerate

    assign scan_done = chain[ffra_pkg::NUM_CELLS].active;

    // Map update: mark the found run at scan end, clear a slot on a free
    always_comb begin
        wr.mark_en = scan_done && chain[ffra_pkg::NUM_CELLS].found && (len_reg != '0);
        wr.clr_en  = s_accept && (s_tuser == ffra_pkg::OP_FREE) && !free_oob;
        if (wr.mark_en) begin
            wr.lo = chain[ffra_pkg::NUM_CELLS].start;
            wr.hi = chain[ffra_pkg::NUM_CELLS].start + ffra_pkg::CNT_W'(len_reg)
                    - ffra_pkg::CNT_W'(1);
        end else begin
            wr.lo = in_idx_ext;
            wr.hi = in_idx_ext;
        end
    end

    // Request control and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            go_reg <= s_accept && (s_tuser == ffra_pkg::OP_ALLOC);
            // output drains here unless a waiting result reloads it
            if (m_tvalid_reg && m_tready && state_reg != S_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser == ffra_pkg::OP_FREE) begin
                            res_status_reg <= free_oob ? ffra_pkg::ST_FAIL : ffra_pkg::ST_OK;
                            res_slot_reg   <= in_idx;
                            state_reg      <= S_RESP;
                        end else begin
                            len_reg   <= in_len;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        if (chain[ffra_pkg::NUM_CELLS].found) begin
                            res_status_reg <= ffra_pkg::ST_OK;
                            res_slot_reg   <=
                                chain[ffra_pkg::NUM_CELLS].start[ffra_pkg::IDX_W-1:0];
                        end else begin
                            res_status_reg <= ffra_pkg::ST_FAIL;
                            res_slot_reg   <= '0;
                        end
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_slot_reg;
                        m_tuser_reg  <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Only one scan token in the chain at a time
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(act_vec))
        else $error("more than one scan token in the cell chain");

    // A token leaves the chain only while an allocate is in progress
    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_done |-> (state_reg == S_SCAN))
        else $error("scan finished outside of an allocate");

    // A run mark and a slot clear never hit the map together
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.mark_en && wr.clr_en))
        else $error("mark and clear in the same cycle");

    // Nothing is accepted while a request is still in flight
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_RESP) |-> !s_tready)
        else $error("input ready while a request is in flight");

endmodule

`default_nettype wire
